/* rtl/core/ledfx_pkg.sv */
// Shared types and constants for the LED effect generator.
package ledfx_pkg;

    // Effect codes, same encoding on the input and output channels.
    typedef enum logic [2:0] {
        EFF_OFF   = 3'd0,
        EFF_ON    = 3'd1,
        EFF_PULSE = 3'd2,
        EFF_FADE  = 3'd3,
        EFF_FIXED = 3'd4
    } t_effect;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SWITCH_DELAY = 2'd0,
        CFG_FLASH_ON     = 2'd1,
        CFG_FLASH_OFF    = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_index;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CDOWN_W    = 32;

    localparam logic [6:0]         LEVEL_FULL  = 7'd127;
    localparam logic [6:0]         LEVEL_ZERO  = 7'd0;
    localparam logic [CDOWN_W-1:0] FADE_PERIOD = 32'd2000;
    localparam logic [CDOWN_W-1:0] FADE_HALF   = 32'd1000;
    localparam logic [CDOWN_W-1:0] CDOWN_MIN   = 32'h8000_0000;

    localparam logic [CFG_DATA_W-1:0] RST_SWITCH_DELAY = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] RST_FLASH_ON     = 16'd50;
    localparam logic [CFG_DATA_W-1:0] RST_FLASH_OFF    = 16'd5000;

    // Input beat.
    typedef struct packed {
        logic [15:0] elapsed_ms;
        logic [2:0]  requested_effect;
    } t_fx_in;

    // Output beat.
    typedef struct packed {
        logic [6:0] led_level;
        logic [2:0] active_effect_out;
    } t_fx_out;

    // Channel state carried from one beat to the next.
    typedef struct packed {
        t_effect             effect;
        logic [CDOWN_W-1:0]  countdown;
        logic [6:0]          level;
    } t_fx_state;

    // Configuration register contents.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] switch_delay_ms;
        logic [CFG_DATA_W-1:0] flash_on_ms;
        logic [CFG_DATA_W-1:0] flash_off_ms;
    } t_fx_cfg;

endpackage

/* rtl/core/led_effect_generator.sv */
// Top level of the LED effect generator: beat registers, state and configuration.
// One LED channel effect engine. Each input beat carries the elapsed milliseconds and the
// requested effect; each one yields exactly one output beat with the LED level and the effect
// in force. A beat passes through the input register, then the result register, and the block
// takes one beat per clock while downstream does not stall, since the whole state update is one
// subtract, one compare and a mux between the input register and the result/state registers.
// Configuration writes are always ready and should be issued only while no beat is in flight.
module led_effect_generator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  ledfx_pkg::t_fx_in     i_data,
    // Output channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output ledfx_pkg::t_fx_out    o_data,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    logic                 r_in_valid;
    ledfx_pkg::t_fx_in    r_in_data;
    logic                 r_out_valid;
    ledfx_pkg::t_fx_out   r_out_data;
    ledfx_pkg::t_fx_state r_state;
    ledfx_pkg::t_fx_state n_state;
    ledfx_pkg::t_fx_cfg   r_cfg;
    logic                 out_free;
    logic                 advance;
    logic                 in_take;

    // Handshake control: the result register frees whenever downstream takes its beat.
    assign out_free    = !r_out_valid || !i_stall;
    assign advance     = r_in_valid && out_free;
    assign o_stall     = r_in_valid && !out_free;
    assign in_take     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_data;
        end
    end

    ledfx_step u_step (
        .i_state (r_state),
        .i_beat  (r_in_data),
        .i_cfg   (r_cfg),
        .o_state (n_state)
    );

    // State and result registers update together when a beat moves forward.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid       <= 1'b0;
            r_state.effect    <= ledfx_pkg::EFF_OFF;
            r_state.countdown <= '0;
            r_state.level     <= ledfx_pkg::LEVEL_ZERO;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_state     <= n_state;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data.led_level         <= n_state.level;
            r_out_data.active_effect_out <= 3'(n_state.effect);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.switch_delay_ms <= ledfx_pkg::RST_SWITCH_DELAY;
            r_cfg.flash_on_ms     <= ledfx_pkg::RST_FLASH_ON;
            r_cfg.flash_off_ms    <= ledfx_pkg::RST_FLASH_OFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (ledfx_pkg::t_cfg_index'(i_cfg_index))
                ledfx_pkg::CFG_SWITCH_DELAY: r_cfg.switch_delay_ms <= i_cfg_data;
                ledfx_pkg::CFG_FLASH_ON:     r_cfg.flash_on_ms     <= i_cfg_data;
                ledfx_pkg::CFG_FLASH_OFF:    r_cfg.flash_off_ms    <= i_cfg_data;
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

endmodule

/* rtl/core/ledfx_step.sv */
// Next-state logic for one beat of the effect engine.
module ledfx_step (
    input  ledfx_pkg::t_fx_state i_state,
    input  ledfx_pkg::t_fx_in    i_beat,
    input  ledfx_pkg::t_fx_cfg   i_cfg,
    output ledfx_pkg::t_fx_state o_state
);

    logic [ledfx_pkg::CDOWN_W:0]   diff_ext;
    logic [ledfx_pkg::CDOWN_W-1:0] cdown_dec;
    logic [ledfx_pkg::CDOWN_W-1:0] fade_off;
    logic [6:0]                    fade_lvl;
    ledfx_pkg::t_effect            req;

    // Codes above fixed count as a repeat of the active effect.
    always_comb begin
        if (i_beat.requested_effect > 3'(ledfx_pkg::EFF_FIXED)) begin
            req = i_state.effect;
        end else begin
            req = ledfx_pkg::t_effect'(i_beat.requested_effect);
        end
    end

    // Countdown drops by the elapsed time, saturating at the most negative value.
    always_comb begin
        diff_ext = {i_state.countdown[ledfx_pkg::CDOWN_W-1], i_state.countdown}
                 - {17'd0, i_beat.elapsed_ms};
        if (diff_ext[ledfx_pkg::CDOWN_W] != diff_ext[ledfx_pkg::CDOWN_W-1]) begin
            cdown_dec = ledfx_pkg::CDOWN_MIN;
        end else begin
            cdown_dec = diff_ext[ledfx_pkg::CDOWN_W-1:0];
        end
    end

    // Triangle level for a non-negative countdown.
    always_comb begin
        fade_off = cdown_dec - ledfx_pkg::FADE_HALF;
        if (cdown_dec < ledfx_pkg::FADE_HALF) begin
            fade_lvl = cdown_dec[9:3];
        end else if (fade_off[ledfx_pkg::CDOWN_W-1:10] != '0) begin
            fade_lvl = ledfx_pkg::LEVEL_ZERO;
        end else begin
            fade_lvl = ledfx_pkg::LEVEL_FULL - fade_off[9:3];
        end
    end

    // Effect selection and per-effect update.
    always_comb begin
        o_state           = i_state;
        o_state.countdown = cdown_dec;
        if (req != i_state.effect) begin
            o_state.effect    = req;
            o_state.countdown = {16'd0, i_cfg.switch_delay_ms};
        end else begin
            unique case (i_state.effect)
                ledfx_pkg::EFF_OFF: begin
                    o_state.level = ledfx_pkg::LEVEL_ZERO;
                end
                ledfx_pkg::EFF_ON: begin
                    o_state.level = ledfx_pkg::LEVEL_FULL;
                end
                ledfx_pkg::EFF_PULSE: begin
                    if (cdown_dec[ledfx_pkg::CDOWN_W-1]) begin
                        if (i_state.level == ledfx_pkg::LEVEL_ZERO) begin
                            o_state.countdown = {16'd0, i_cfg.flash_on_ms};
                            o_state.level     = ledfx_pkg::LEVEL_FULL;
                        end else begin
                            o_state.countdown = {16'd0, i_cfg.flash_off_ms};
                            o_state.level     = ledfx_pkg::LEVEL_ZERO;
                        end
                    end
                end
                ledfx_pkg::EFF_FADE: begin
                    if (cdown_dec[ledfx_pkg::CDOWN_W-1]) begin
                        o_state.countdown = ledfx_pkg::FADE_PERIOD;
                    end else begin
                        o_state.level = fade_lvl;
                    end
                end
                default: begin
                    // Fixed keeps its level.
                end
            endcase
        end
    end

endmodule

/* rtl/core/ledfx_checker.sv */
// Port-level checker for the LED effect generator, bound to the top level.
module ledfx_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_stall,
    input  logic               o_valid,
    input  logic               i_stall,
    input  ledfx_pkg::t_fx_out o_data
);

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    // With the result register empty, the input side is never stalled.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while result register empty");

    // Reported effect is always a defined code.
    a_effect_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.active_effect_out <= 3'(ledfx_pkg::EFF_FIXED))
        else $error("undefined effect code on output");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind led_effect_generator ledfx_checker u_ledfx_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

/* test/tb_top.sv */
// Testbench for the LED effect generator: directed and random beats checked by a scoreboard.
`timescale 1ns / 100ps

module tb_top;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          SOAK_BEATS    = 64;
    localparam int          RANDOM_BEATS  = 290;
    localparam logic [2:0]  REQ_UNKNOWN_LO = 3'd5;
    localparam logic [2:0]  REQ_CODE_MAX   = 3'd7;

    // Tracks the channel state, predicts each output beat and checks what comes out.
    class fx_shadow;
        logic [15:0]          switch_delay;
        logic [15:0]          flash_on;
        logic [15:0]          flash_off;
        ledfx_pkg::t_effect   effect;
        int                   countdown;
        logic [6:0]           level;
        ledfx_pkg::t_fx_out   pending_levels[$];
        int                   errors;
        int                   results_seen;

        function new();
            switch_delay = ledfx_pkg::RST_SWITCH_DELAY;
            flash_on     = ledfx_pkg::RST_FLASH_ON;
            flash_off    = ledfx_pkg::RST_FLASH_OFF;
            effect       = ledfx_pkg::EFF_OFF;
            countdown    = 0;
            level        = ledfx_pkg::LEVEL_ZERO;
            errors       = 0;
            results_seen = 0;
        endfunction

        // Writes to the unused index leave every register alone.
        function void write_reg(ledfx_pkg::t_cfg_index idx, logic [15:0] val);
            case (idx)
                ledfx_pkg::CFG_SWITCH_DELAY: switch_delay = val;
                ledfx_pkg::CFG_FLASH_ON:     flash_on = val;
                ledfx_pkg::CFG_FLASH_OFF:    flash_off = val;
                default: ;
            endcase
        endfunction

        // Triangle level traced from a non-negative countdown.
        function logic [6:0] fade_level(int t);
            int d;
            if (t < int'(ledfx_pkg::FADE_HALF)) return 7'(t >>> 3);
            d = (t - int'(ledfx_pkg::FADE_HALF)) >>> 3;
            if (d > int'(ledfx_pkg::LEVEL_FULL)) return ledfx_pkg::LEVEL_ZERO;
            return ledfx_pkg::LEVEL_FULL - 7'(d);
        endfunction

        function void take_request(ledfx_pkg::t_fx_in beat);
            logic [2:0]         req;
            longint             diff;
            ledfx_pkg::t_fx_out res;
            req = beat.requested_effect;
            // Unknown codes repeat whatever effect is running.
            if (req > ledfx_pkg::EFF_FIXED) req = effect;

            // The countdown drops first and sticks at its floor rather than wrapping.
            diff = longint'(countdown) - longint'(beat.elapsed_ms);
            if (diff < longint'(int'(ledfx_pkg::CDOWN_MIN))) begin
                countdown = int'(ledfx_pkg::CDOWN_MIN);
            end else begin
                countdown = int'(diff);
            end

            if (req != effect) begin
                effect    = ledfx_pkg::t_effect'(req);
                countdown = int'({16'd0, switch_delay});
            end else begin
                case (effect)
                    ledfx_pkg::EFF_OFF: level = ledfx_pkg::LEVEL_ZERO;
                    ledfx_pkg::EFF_ON:  level = ledfx_pkg::LEVEL_FULL;
                    ledfx_pkg::EFF_PULSE: begin
                        if (countdown < 0) begin
                            if (level == ledfx_pkg::LEVEL_ZERO) begin
                                countdown = int'({16'd0, flash_on});
                                level     = ledfx_pkg::LEVEL_FULL;
                            end else begin
                                countdown = int'({16'd0, flash_off});
                                level     = ledfx_pkg::LEVEL_ZERO;
                            end
                        end
                    end
                    ledfx_pkg::EFF_FADE: begin
                        if (countdown < 0) countdown = int'(ledfx_pkg::FADE_PERIOD);
                        else level = fade_level(countdown);
                    end
                    default: ;
                endcase
            end

            res.led_level         = level;
            res.active_effect_out = effect;
            pending_levels.push_back(res);
        endfunction

        function void match_output(ledfx_pkg::t_fx_out got);
            ledfx_pkg::t_fx_out want;
            results_seen++;
            if (pending_levels.size() == 0) begin
                $display("%0t: output beat with nothing expected, level %0d effect %0d",
                         $time, got.led_level, got.active_effect_out);
                errors++;
                return;
            end
            want = pending_levels.pop_front();
            if (got.led_level !== want.led_level) begin
                $display("%0t: led_level mismatch, expected %0d, actual %0d",
                         $time, want.led_level, got.led_level);
                errors++;
            end
            if (got.active_effect_out !== want.active_effect_out) begin
                $display("%0t: active_effect_out mismatch, expected %0d, actual %0d",
                         $time, want.active_effect_out, got.active_effect_out);
                errors++;
            end
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    ledfx_pkg::t_fx_in  i_data      = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    ledfx_pkg::t_fx_out o_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data  = '0;

    fx_shadow    shadow = new();
    int          snd_idle = 0;
    int          rcv_idle = 0;
    int          beats_in = 0;
    int          cfg_writes = 0;
    int          cycles = 0;

    led_effect_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rcv_idle);
    end

    // Watch both channels and the register port at every edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                shadow.write_reg(ledfx_pkg::t_cfg_index'(i_cfg_index), i_cfg_data);
                cfg_writes++;
            end
            if (i_valid && !o_stall) begin
                shadow.take_request(i_data);
                beats_in++;
            end
            if (o_valid === 1'b1 && !i_stall) shadow.match_output(o_data);
        end
    end

    // Offers one beat, possibly after some idle cycles, and returns at its acceptance edge.
    task automatic send_fx(input logic [15:0] elapsed, input logic [2:0] req);
        while ($urandom_range(0, 99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid                 <= 1'b1;
        i_data.elapsed_ms       <= elapsed;
        i_data.requested_effect <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic write_reg(input ledfx_pkg::t_cfg_index idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Holds the input off until every predicted beat has been seen, plus a margin.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] sd, input logic [15:0] fon,
                                  input logic [15:0] foff);
        write_reg(ledfx_pkg::CFG_FLASH_OFF, foff);
        write_reg(ledfx_pkg::CFG_UNUSED, 16'($urandom));
        write_reg(ledfx_pkg::CFG_SWITCH_DELAY, sd);
        write_reg(ledfx_pkg::CFG_FLASH_ON, fon);
    endtask

    function automatic logic [15:0] pick_elapsed();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 16'($urandom_range(0, 300));
        if (r < 70) return 16'($urandom_range(0, 3000));
        if (r < 90) return 16'($urandom_range(0, 20000));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_setting();
        if ($urandom_range(0, 99) < 75) return 16'($urandom_range(0, 6000));
        return 16'($urandom);
    endfunction

    // Runs of one effect with random timing, sprinkled with unknown codes and stray requests.
    task automatic run_random(input int count);
        int          sent;
        int          run_len;
        int unsigned r;
        logic [2:0]  eff;
        logic [2:0]  req;
        sent = 0;
        while (sent < count) begin
            eff     = 3'($urandom_range(ledfx_pkg::EFF_OFF, ledfx_pkg::EFF_FIXED));
            run_len = $urandom_range(1, 40);
            for (int k = 0; k < run_len && sent < count; k++) begin
                r = $urandom_range(0, 99);
                if (r < 90) req = eff;
                else if (r < 95) req = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_CODE_MAX));
                else req = 3'($urandom_range(0, REQ_CODE_MAX));
                send_fx(pick_elapsed(), req);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle = 38;
        rcv_idle = 80;

        // Directed sequence at the reset settings: every effect, pulse both ways,
        // fade across its triangle and its reload, unknown codes and a dead index write.
        write_reg(ledfx_pkg::CFG_UNUSED, 16'hFFFF);
        send_fx(16'd0,     ledfx_pkg::EFF_OFF);
        send_fx(16'hFFFF,  ledfx_pkg::EFF_ON);
        send_fx(16'd0,     ledfx_pkg::EFF_ON);
        send_fx(16'd100,   ledfx_pkg::EFF_PULSE);
        send_fx(16'd2001,  ledfx_pkg::EFF_PULSE);
        send_fx(16'd5001,  ledfx_pkg::EFF_PULSE);
        send_fx(16'd51,    ledfx_pkg::EFF_PULSE);
        send_fx(16'd0,     ledfx_pkg::EFF_FADE);
        send_fx(16'd0,     ledfx_pkg::EFF_FADE);
        send_fx(16'd1000,  ledfx_pkg::EFF_FADE);
        send_fx(16'd999,   ledfx_pkg::EFF_FADE);
        send_fx(16'd1,     ledfx_pkg::EFF_FADE);
        send_fx(16'd1,     ledfx_pkg::EFF_FADE);
        send_fx(16'd500,   REQ_UNKNOWN_LO);
        send_fx(16'd0,     REQ_CODE_MAX);
        send_fx(16'd0,     ledfx_pkg::EFF_FIXED);
        send_fx(16'hFFFF,  ledfx_pkg::EFF_FIXED);
        settle();

        // A long switch delay puts fade far beyond its triangle, where it holds zero.
        write_reg(ledfx_pkg::CFG_SWITCH_DELAY, 16'hFFFF);
        send_fx(16'd0,     ledfx_pkg::EFF_FADE);
        send_fx(16'd0,     ledfx_pkg::EFF_FADE);
        send_fx(16'hFFFF,  ledfx_pkg::EFF_FADE);
        settle();

        // Zero-length flashes.
        apply_settings(16'd0, 16'd0, 16'd0);
        send_fx(16'd0, ledfx_pkg::EFF_PULSE);
        send_fx(16'd0, ledfx_pkg::EFF_PULSE);
        send_fx(16'd1, ledfx_pkg::EFF_PULSE);
        send_fx(16'd1, ledfx_pkg::EFF_PULSE);
        settle();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    snd_idle = 38;
                    rcv_idle = 80;
                end
                1: begin
                    snd_idle = 80;
                    rcv_idle = 38;
                end
                default: begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
            endcase

            if (phase == 2) begin
                // Drive the countdown far negative while fixed, then leave fixed.
                send_fx(16'd0, ledfx_pkg::EFF_FIXED);
                for (int k = 0; k < SOAK_BEATS; k++) send_fx(16'hFFFF, ledfx_pkg::EFF_FIXED);
                send_fx(16'd0, ledfx_pkg::EFF_PULSE);
                send_fx(16'hFFFF, ledfx_pkg::EFF_PULSE);
            end

            for (int half = 0; half < 2; half++) begin
                settle();
                if (half == 1) begin
                    apply_settings(pick_setting(), pick_setting(), pick_setting());
                end else if (phase == 0) begin
                    apply_settings(16'd0, 16'd0, 16'd0);
                end else if (phase == 1) begin
                    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
                end else begin
                    apply_settings(ledfx_pkg::RST_SWITCH_DELAY, ledfx_pkg::RST_FLASH_ON,
                                   ledfx_pkg::RST_FLASH_OFF);
                end
                run_random(RANDOM_BEATS);
            end
        end
        settle();

        $display("Sent %0d beats and checked %0d results across %0d register writes,",
                 beats_in, shadow.results_seen, cfg_writes);
        $display("with both sides idling in turn and a long negative countdown soak.");
        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ledfx_pkg.sv
rtl/core/ledfx_step.sv
rtl/core/led_effect_generator.sv
rtl/core/ledfx_checker.sv
test/tb_top.sv
